[sv/vdpd_pkg.sv]
`default_nettype none
// ============================================================================
// vdpd_pkg
// Shared types and constants of the varint delta polygon decoder.
// ============================================================================
package vdpd_pkg;

    localparam int PTR_W     = 2;
    localparam int RES_DEPTH = 1 << PTR_W;
    localparam int CNT_W     = PTR_W + 1;
    localparam int MAX_PUSH  = 3;

    typedef enum logic [2:0] {
        PH_RINGS,
        PH_POINTS,
        PH_LON,
        PH_LAT,
        PH_DRAIN
    } phase_t;

    typedef enum logic [1:0] {
        KIND_POINT,
        KIND_CLOSE,
        KIND_DONE,
        KIND_ERROR
    } kind_t;

    typedef enum logic [2:0] {
        ERR_NONE,
        ERR_TRUNCATED,
        ERR_OVERFLOW,
        ERR_SHORT_RING,
        ERR_ZERO_RINGS,
        ERR_TRAILING
    } err_t;

    typedef struct packed {
        kind_t              kind;
        err_t               err;
        logic signed [31:0] lon;
        logic signed [31:0] lat;
        logic [15:0]        poly;
        logic [31:0]        ring;
        logic [31:0]        point;
        logic               ring_end;
        logic               last;
    } result_t;

    typedef struct packed {
        logic [1:0]   n;
        result_t [2:0] slot;
    } push_t;

endpackage
`default_nettype wire

[sv/vdpd_byte_if.sv]
`default_nettype none
// ============================================================================
// vdpd_byte_if
// Byte stream channel: one encoded byte per beat, last byte marked.
// ============================================================================
interface vdpd_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface
`default_nettype wire

[sv/vdpd_cfg_if.sv]
`default_nettype none
// ============================================================================
// vdpd_cfg_if
// Configuration write channel carrying the polygon count register.
// ============================================================================
interface vdpd_cfg_if;
    logic        valid;
    logic        ready;
    logic [15:0] polygon_count;

    modport source (output valid, output polygon_count, input ready);
    modport sink (input valid, input polygon_count, output ready);
endinterface
`default_nettype wire

[sv/vdpd_result_if.sv]
`default_nettype none
// ============================================================================
// vdpd_result_if
// Result channel: one decoded point, closing point or status per beat.
// ============================================================================
interface vdpd_result_if;
    logic               valid;
    logic               ready;
    logic [1:0]         result_kind;
    logic [2:0]         error_code;
    logic signed [31:0] longitude_fixed;
    logic signed [31:0] latitude_fixed;
    logic [15:0]        polygon_index;
    logic [31:0]        ring_index;
    logic [31:0]        point_index;
    logic               ring_end;
    logic               last_result;

    modport source (
        output valid, output result_kind, output error_code,
        output longitude_fixed, output latitude_fixed, output polygon_index,
        output ring_index, output point_index, output ring_end,
        output last_result, input ready
    );
    modport sink (
        input valid, input result_kind, input error_code,
        input longitude_fixed, input latitude_fixed, input polygon_index,
        input ring_index, input point_index, input ring_end,
        input last_result, output ready
    );
endinterface
`default_nettype wire

[sv/vdpd_core.sv]
`default_nettype none
// ============================================================================
// vdpd_core
// Input byte register and combinational varint/delta decode of one byte.
// ============================================================================
module vdpd_core (
    input  logic                 clk,
    input  logic                 rst_n,
    vdpd_byte_if.sink            bytes,
    input  logic [15:0]          polygon_count,
    input  logic                 room,
    output vdpd_pkg::push_t      push
);

    logic                in_valid_reg;
    logic                in_valid_next;
    logic [7:0]          in_byte_reg;
    logic                in_last_reg;
    logic                accept;
    logic                fire;

    vdpd_pkg::phase_t    phase_reg,     phase_next;
    logic [31:0]         acc_reg,       acc_next;
    logic [2:0]          cnt_reg,       cnt_next;
    logic [15:0]         poly_reg,      poly_next;
    logic [31:0]         rings_reg,     rings_next;
    logic [31:0]         ring_reg,      ring_next;
    logic [31:0]         points_reg,    points_next;
    logic [31:0]         point_reg,     point_next;
    logic [31:0]         run_lon_reg,   run_lon_next;
    logic [31:0]         run_lat_reg,   run_lat_next;
    logic [31:0]         first_lon_reg, first_lon_next;
    logic [31:0]         first_lat_reg, first_lat_next;

    // Decode terms shared by the next-state and output logic.
    logic                active;
    logic                trailing;
    logic                cont;
    logic [2:0]          cnt_clamp;
    logic [2:0]          cnt_inc;
    logic [4:0]          shift;
    logic [31:0]         acc_new;
    logic [31:0]         delta;
    logic                is_first;
    logic [31:0]         lon_sum;
    logic [31:0]         lat_sum;
    logic [31:0]         first_lon_eff;
    logic [31:0]         first_lat_eff;
    logic [31:0]         point_inc;
    logic [31:0]         ring_inc;
    logic [15:0]         poly_inc;
    logic                final_pt;
    logic                ring_last;
    logic                closes;
    logic                lat_done;
    logic                done_ok;
    vdpd_pkg::err_t      err;

    assign accept       = bytes.valid && bytes.ready;
    assign fire         = in_valid_reg && room;
    assign bytes.ready  = !in_valid_reg || room;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (accept)
        begin
            in_valid_next = 1'b1;
        end
        else if (fire)
        begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_byte_reg <= bytes.data_byte;
            in_last_reg <= bytes.last_byte;
        end
    end

    // ------------------------------------------------------------------
    // Byte decode
    // ------------------------------------------------------------------
    always_comb
    begin
        active    = (phase_reg != vdpd_pkg::PH_DRAIN);
        trailing  = (phase_reg == vdpd_pkg::PH_RINGS) && (poly_reg >= polygon_count);
        cont      = in_byte_reg[7];
        cnt_clamp = (cnt_reg > 3'd4) ? 3'd4 : cnt_reg;
        cnt_inc   = cnt_clamp + 3'd1;
        unique case (cnt_clamp)
            3'd0:    shift = 5'd0;
            3'd1:    shift = 5'd7;
            3'd2:    shift = 5'd14;
            3'd3:    shift = 5'd21;
            default: shift = 5'd28;
        endcase
        acc_new   = acc_reg | ({25'd0, in_byte_reg[6:0]} << shift);
        delta     = {1'b0, acc_new[31:1]} ^ {32{acc_new[0]}};
        is_first  = (point_reg == 32'd0);
        lon_sum   = is_first ? delta : run_lon_reg + delta;
        lat_sum   = is_first ? delta : run_lat_reg + delta;
        first_lon_eff = is_first ? run_lon_reg : first_lon_reg;
        first_lat_eff = is_first ? lat_sum : first_lat_reg;
        point_inc = point_reg + 32'd1;
        ring_inc  = ring_reg + 32'd1;
        poly_inc  = poly_reg + 16'd1;
        final_pt  = (point_inc == points_reg);
        ring_last = (ring_inc == rings_reg);
        closes    = (run_lon_reg == first_lon_eff) && (lat_sum == first_lat_eff);
        lat_done  = (phase_reg == vdpd_pkg::PH_LAT) && !cont;
        // The boundary is complete only when this byte closes the last ring
        // of the last expected polygon.
        done_ok   = lat_done && final_pt && ring_last && (poly_inc >= polygon_count);

        priority if (!active)
        begin
            err = vdpd_pkg::ERR_NONE;
        end
        else if (trailing)
        begin
            err = vdpd_pkg::ERR_TRAILING;
        end
        else if (cont)
        begin
            err = (cnt_inc >= 3'd5) ? vdpd_pkg::ERR_OVERFLOW : vdpd_pkg::ERR_NONE;
        end
        else if ((phase_reg == vdpd_pkg::PH_RINGS) && (acc_new == 32'd0))
        begin
            err = vdpd_pkg::ERR_ZERO_RINGS;
        end
        else if ((phase_reg == vdpd_pkg::PH_POINTS) && (acc_new < 32'd3))
        begin
            err = vdpd_pkg::ERR_SHORT_RING;
        end
        else
        begin
            err = vdpd_pkg::ERR_NONE;
        end
    end

    // ------------------------------------------------------------------
    // Next state
    // ------------------------------------------------------------------
    always_comb
    begin
        phase_next     = phase_reg;
        acc_next       = acc_reg;
        cnt_next       = cnt_reg;
        poly_next      = poly_reg;
        rings_next     = rings_reg;
        ring_next      = ring_reg;
        points_next    = points_reg;
        point_next     = point_reg;
        run_lon_next   = run_lon_reg;
        run_lat_next   = run_lat_reg;
        first_lon_next = first_lon_reg;
        first_lat_next = first_lat_reg;

        if (fire && active && !trailing)
        begin
            if (cont)
            begin
                acc_next = acc_new;
                cnt_next = cnt_inc;
            end
            else
            begin
                acc_next = 32'd0;
                cnt_next = 3'd0;
                unique case (phase_reg)
                    vdpd_pkg::PH_RINGS:
                    begin
                        if (err == vdpd_pkg::ERR_NONE)
                        begin
                            rings_next = acc_new;
                            ring_next  = 32'd0;
                            phase_next = vdpd_pkg::PH_POINTS;
                        end
                    end
                    vdpd_pkg::PH_POINTS:
                    begin
                        if (err == vdpd_pkg::ERR_NONE)
                        begin
                            points_next = acc_new;
                            point_next  = 32'd0;
                            phase_next  = vdpd_pkg::PH_LON;
                        end
                    end
                    vdpd_pkg::PH_LON:
                    begin
                        run_lon_next = lon_sum;
                        phase_next   = vdpd_pkg::PH_LAT;
                    end
                    vdpd_pkg::PH_LAT:
                    begin
                        run_lat_next = lat_sum;
                        if (is_first)
                        begin
                            first_lon_next = run_lon_reg;
                            first_lat_next = lat_sum;
                        end
                        point_next = point_inc;
                        if (final_pt)
                        begin
                            ring_next = ring_inc;
                            if (ring_last)
                            begin
                                poly_next  = poly_inc;
                                phase_next = vdpd_pkg::PH_RINGS;
                            end
                            else
                            begin
                                phase_next = vdpd_pkg::PH_POINTS;
                            end
                        end
                        else
                        begin
                            phase_next = vdpd_pkg::PH_LON;
                        end
                    end
                    vdpd_pkg::PH_DRAIN:
                    begin
                        phase_next = phase_reg;
                    end
                    default:
                    begin
                        phase_next = vdpd_pkg::PH_RINGS;
                    end
                endcase
            end
        end

        if (fire && (err != vdpd_pkg::ERR_NONE) && !in_last_reg)
        begin
            phase_next = vdpd_pkg::PH_DRAIN;
            acc_next   = 32'd0;
            cnt_next   = 3'd0;
        end

        // The marked last byte always returns the block to idle.
        if (fire && in_last_reg)
        begin
            phase_next     = vdpd_pkg::PH_RINGS;
            acc_next       = 32'd0;
            cnt_next       = 3'd0;
            poly_next      = 16'd0;
            rings_next     = 32'd0;
            ring_next      = 32'd0;
            points_next    = 32'd0;
            point_next     = 32'd0;
            run_lon_next   = 32'd0;
            run_lat_next   = 32'd0;
            first_lon_next = 32'd0;
            first_lat_next = 32'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= vdpd_pkg::PH_RINGS;
            acc_reg       <= 32'd0;
            cnt_reg       <= 3'd0;
            poly_reg      <= 16'd0;
            rings_reg     <= 32'd0;
            ring_reg      <= 32'd0;
            points_reg    <= 32'd0;
            point_reg     <= 32'd0;
            run_lon_reg   <= 32'd0;
            run_lat_reg   <= 32'd0;
            first_lon_reg <= 32'd0;
            first_lat_reg <= 32'd0;
        end
        else
        begin
            phase_reg     <= phase_next;
            acc_reg       <= acc_next;
            cnt_reg       <= cnt_next;
            poly_reg      <= poly_next;
            rings_reg     <= rings_next;
            ring_reg      <= ring_next;
            points_reg    <= points_next;
            point_reg     <= point_next;
            run_lon_reg   <= run_lon_next;
            run_lat_reg   <= run_lat_next;
            first_lon_reg <= first_lon_next;
            first_lat_reg <= first_lat_next;
        end
    end

    // ------------------------------------------------------------------
    // Results of this byte, packed into consecutive slots
    // ------------------------------------------------------------------
    always_comb
    begin
        vdpd_pkg::result_t pt_res;
        vdpd_pkg::result_t cl_res;
        vdpd_pkg::result_t tl_res;
        logic              p_valid;
        logic              c_valid;
        logic              t_valid;

        p_valid = fire && active && !trailing && lat_done;
        c_valid = p_valid && final_pt && !closes;
        t_valid = fire && active && ((err != vdpd_pkg::ERR_NONE) || in_last_reg);

        pt_res.kind     = vdpd_pkg::KIND_POINT;
        pt_res.err      = vdpd_pkg::ERR_NONE;
        pt_res.lon      = run_lon_reg;
        pt_res.lat      = lat_sum;
        pt_res.poly     = poly_reg;
        pt_res.ring     = ring_reg;
        pt_res.point    = point_reg;
        pt_res.ring_end = final_pt && closes;
        pt_res.last     = !c_valid && !t_valid;

        cl_res.kind     = vdpd_pkg::KIND_CLOSE;
        cl_res.err      = vdpd_pkg::ERR_NONE;
        cl_res.lon      = first_lon_eff;
        cl_res.lat      = first_lat_eff;
        cl_res.poly     = poly_reg;
        cl_res.ring     = ring_reg;
        cl_res.point    = point_inc;
        cl_res.ring_end = 1'b1;
        cl_res.last     = !t_valid;

        tl_res.lon      = 32'sd0;
        tl_res.lat      = 32'sd0;
        tl_res.poly     = 16'd0;
        tl_res.ring     = 32'd0;
        tl_res.point    = 32'd0;
        tl_res.ring_end = 1'b0;
        tl_res.last     = 1'b1;
        if (err != vdpd_pkg::ERR_NONE)
        begin
            tl_res.kind = vdpd_pkg::KIND_ERROR;
            tl_res.err  = err;
        end
        else if (done_ok)
        begin
            tl_res.kind = vdpd_pkg::KIND_DONE;
            tl_res.err  = vdpd_pkg::ERR_NONE;
        end
        else
        begin
            tl_res.kind = vdpd_pkg::KIND_ERROR;
            tl_res.err  = vdpd_pkg::ERR_TRUNCATED;
        end

        push.n       = {1'b0, p_valid} + {1'b0, c_valid} + {1'b0, t_valid};
        push.slot[0] = p_valid ? pt_res : tl_res;
        push.slot[1] = c_valid ? cl_res : tl_res;
        push.slot[2] = tl_res;
    end

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_drain_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && (phase_reg == vdpd_pkg::PH_DRAIN)) |-> (push.n == 2'd0))
        else $error("results produced while draining after an error");

    a_varint_len: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= 3'd4)
        else $error("varint byte count beyond four");

    a_last_idles: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && in_last_reg) |=> ((phase_reg == vdpd_pkg::PH_RINGS) &&
                                   (cnt_reg == 3'd0) && (poly_reg == 16'd0)))
        else $error("last byte did not return the decoder to idle");

endmodule
`default_nettype wire

[sv/vdpd_result_fifo.sv]
`default_nettype none
// ============================================================================
// vdpd_result_fifo
// Small result queue: up to three writes per cycle, one read per cycle.
// ============================================================================
module vdpd_result_fifo (
    input  logic             clk,
    input  logic             rst_n,
    input  vdpd_pkg::push_t  push,
    output logic             room,
    vdpd_result_if.source    results
);

    vdpd_pkg::result_t                 mem_reg [vdpd_pkg::RES_DEPTH];
    logic [vdpd_pkg::PTR_W-1:0]        wr_ptr_reg, wr_ptr_next;
    logic [vdpd_pkg::PTR_W-1:0]        rd_ptr_reg, rd_ptr_next;
    logic [vdpd_pkg::CNT_W-1:0]        count_reg,  count_next;
    logic                              pop;
    vdpd_pkg::result_t                 head;

    // Room is judged on the registered count so that ready does not depend
    // on the downstream ready.
    assign room = count_reg <=
                  vdpd_pkg::CNT_W'(vdpd_pkg::RES_DEPTH - vdpd_pkg::MAX_PUSH);
    assign pop  = results.valid && results.ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + vdpd_pkg::PTR_W'(push.n);
        rd_ptr_next = rd_ptr_reg + vdpd_pkg::PTR_W'(pop);
        count_next  = count_reg + vdpd_pkg::CNT_W'(push.n) - vdpd_pkg::CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < vdpd_pkg::MAX_PUSH; k++)
        begin
            if (k < int'(push.n))
            begin
                mem_reg[wr_ptr_reg + vdpd_pkg::PTR_W'(k)] <= push.slot[k];
            end
        end
    end

    assign head                    = mem_reg[rd_ptr_reg];
    assign results.valid           = (count_reg != '0);
    assign results.result_kind     = head.kind;
    assign results.error_code      = head.err;
    assign results.longitude_fixed = head.lon;
    assign results.latitude_fixed  = head.lat;
    assign results.polygon_index   = head.poly;
    assign results.ring_index      = head.ring;
    assign results.point_index     = head.point;
    assign results.ring_end        = head.ring_end;
    assign results.last_result     = head.last;

    a_no_overfill: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= vdpd_pkg::CNT_W'(vdpd_pkg::RES_DEPTH))
        else $error("result queue holds more than its depth");

    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        (push.n != 2'd0) |-> room)
        else $error("results pushed without room for a whole byte");

    a_pop_only: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && (push.n == 2'd0)) |=> (count_reg == $past(count_reg) - 1'b1))
        else $error("queue count did not drop after a lone read");

endmodule
`default_nettype wire

[sv/varint_delta_polygon_decoder_top.sv]
`default_nettype none
// ============================================================================
// varint_delta_polygon_decoder_top
// Zigzag varint delta polygon decoder: encoded boundary bytes in, points out.
// ============================================================================
// Usage:
//   cfg     : write the polygon count while the block is idle; always ready.
//   bytes   : one encoded byte per beat, last_byte set on the final byte.
//   results : one point, closing point, completion or error per beat;
//             last_result marks the final result caused by a byte.
// Timing: a byte is decoded in the cycle after it is taken, and its results
//   are written into the result queue, which offers them.
// Throughput: one byte per cycle while results is ready and each byte gives
//   at most one result. A byte can give up to three results; the four-entry
//   result queue drains one per cycle, and the byte register only moves on
//   while the queue has three free entries, so such bytes hold the input back.
// Stalls: when results is not ready the queue fills, the byte register
//   holds, and bytes.ready drops; nothing is lost or repeated.
// Reset: clears the polygon count to zero, empties the queue and returns
//   the decoder to idle, expecting a ring count.
// ============================================================================
module varint_delta_polygon_decoder_top (
    input  logic           clk,
    input  logic           rst_n,
    vdpd_cfg_if.sink       cfg,
    vdpd_byte_if.sink      bytes,
    vdpd_result_if.source  results
);

    logic [15:0]      polygon_count_reg;
    logic [15:0]      polygon_count_next;
    logic             room;
    vdpd_pkg::push_t  push;

    assign cfg.ready = 1'b1;

    always_comb
    begin
        polygon_count_next = polygon_count_reg;
        if (cfg.valid && cfg.ready)
        begin
            polygon_count_next = cfg.polygon_count;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            polygon_count_reg <= 16'd0;
        end
        else
        begin
            polygon_count_reg <= polygon_count_next;
        end
    end

    vdpd_core u_core (
        .clk           (clk),
        .rst_n         (rst_n),
        .bytes         (bytes),
        .polygon_count (polygon_count_reg),
        .room          (room),
        .push          (push)
    );

    vdpd_result_fifo u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .room    (room),
        .results (results)
    );

endmodule
`default_nettype wire
